### hw/rtl/crr_pkg.sv
// Shared types, constants and the binomial ROM of the combination rank/unrank block.
`timescale 1ns / 1ps
`default_nettype none
package crr_pkg;

  // Field widths
  localparam int MASK_W  = 16;
  localparam int INDEX_W = 14;
  localparam int IDX_W   = 16;
  localparam int CNT_W   = $clog2(MASK_W + 1);
  localparam int POS_W   = $clog2(MASK_W);
  localparam int CFG_W   = 5;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 3;

  // Default for the top-level set size cap
  localparam int MAX_SET_DEF = 16;

  // Register byte addresses
  localparam logic [APB_AW-1:0] ADDR_SET_SIZE    = 3'd0;
  localparam logic [APB_AW-1:0] ADDR_SUBSET_SIZE = 3'd4;

  // Reset values of the registers
  localparam logic [CFG_W-1:0] SET_SIZE_RST    = 5'd16;
  localparam logic [CFG_W-1:0] SUBSET_SIZE_RST = 5'd8;

  typedef enum logic {
    OP_RANK   = 1'b0,
    OP_UNRANK = 1'b1
  } crr_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } crr_state_e;

  // Request to and response from the shared step unit
  typedef struct packed {
    crr_op_e              op;
    logic                 bit_in;
    logic [POS_W-1:0]     a;
    logic [CNT_W-1:0]     r;
    logic [IDX_W-1:0]     acc;
  } crr_step_req_t;

  typedef struct packed {
    logic                 take;
    logic [CNT_W-1:0]     r;
    logic [IDX_W-1:0]     acc;
  } crr_step_rsp_t;

  // Pascal triangle C(a,b) for a, b below MASK_W
  typedef logic [MASK_W-1:0][MASK_W-1:0][INDEX_W-1:0] binom_tab_t;

  function automatic binom_tab_t pascal_rom();
    binom_tab_t t;
    t = '0;
    for (int a = 0; a < MASK_W; a++) begin
      for (int b = 0; b < MASK_W; b++) begin
        if (b == 0) begin
          t[a][b] = INDEX_W'(1);
        end else if (a > 0) begin
          t[a][b] = t[a-1][b-1] + t[a-1][b];
        end
      end
    end
    return t;
  endfunction

  localparam binom_tab_t BINOM = pascal_rom();

endpackage
`default_nettype wire

### hw/rtl/crr_apb_regs.sv
// APB register file holding set size and subset size.
`timescale 1ns / 1ps
`default_nettype none
module crr_apb_regs
  import crr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output logic      [CFG_W-1:0]  set_size_o,
  output logic      [CFG_W-1:0]  subset_size_o
);

  logic [CFG_W-1:0] set_size_q, set_size_d;
  logic [CFG_W-1:0] subset_size_q, subset_size_d;
  logic             wr_en;
  logic             sel_subset;

  assign pready     = 1'b1;
  assign wr_en      = psel & penable & pwrite & pready;
  // Decode on the word address bit only
  assign sel_subset = (paddr[2] == ADDR_SUBSET_SIZE[2]);

  // Take the write data on the access cycle
  always_comb begin
    set_size_d    = set_size_q;
    subset_size_d = subset_size_q;
    if (wr_en) begin
      if (sel_subset) begin
        subset_size_d = pwdata[CFG_W-1:0];
      end else begin
        set_size_d = pwdata[CFG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_size_q    <= SET_SIZE_RST;
      subset_size_q <= SUBSET_SIZE_RST;
    end else begin
      set_size_q    <= set_size_d;
      subset_size_q <= subset_size_d;
    end
  end

  // Read back
  assign prdata = sel_subset ? {{(APB_DW-CFG_W){1'b0}}, subset_size_q}
                             : {{(APB_DW-CFG_W){1'b0}}, set_size_q};

  assign set_size_o    = set_size_q;
  assign subset_size_o = subset_size_q;

endmodule
`default_nettype wire

### hw/rtl/crr_step_unit.sv
// Shared step unit: binomial ROM lookup with one add, subtract and compare.
`timescale 1ns / 1ps
`default_nettype none
module crr_step_unit
  import crr_pkg::*;
(
  input  wire crr_step_req_t req_i,
  output crr_step_rsp_t      rsp_o
);

  logic [CNT_W-1:0]   r_m1;
  logic               hit;
  logic [INDEX_W-1:0] coef;
  logic [IDX_W-1:0]   coef_x;
  logic               below;

  // C(a, r-1), zero when r is zero or r-1 exceeds a
  assign r_m1   = req_i.r - CNT_W'(1);
  assign hit    = (req_i.r != '0) && (r_m1 <= CNT_W'(req_i.a));
  assign coef   = hit ? BINOM[req_i.a][r_m1[POS_W-1:0]] : '0;
  assign coef_x = IDX_W'(coef);
  assign below  = req_i.acc < coef_x;

  always_comb begin
    rsp_o = '{take: 1'b0, r: req_i.r, acc: req_i.acc};
    unique case (req_i.op)
      OP_RANK: begin
        // Present element uses a slot, absent one adds the skipped subsets
        rsp_o.take = req_i.bit_in;
        if (req_i.bit_in) begin
          if (req_i.r != '0) begin
            rsp_o.r = r_m1;
          end
        end else begin
          rsp_o.acc = req_i.acc + coef_x;
        end
      end
      OP_UNRANK: begin
        // Choose the element when the remainder falls inside its block
        if (req_i.r != '0) begin
          if (below) begin
            rsp_o.take = 1'b1;
            rsp_o.r    = r_m1;
          end else begin
            rsp_o.acc = req_i.acc - coef_x;
          end
        end
      end
      default: begin
        rsp_o = '{take: 1'b0, r: req_i.r, acc: req_i.acc};
      end
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/crr_engine.sv
// Sequencer walking the set one position a cycle through the step unit; the last waits for a free output.
`timescale 1ns / 1ps
`default_nettype none
module crr_engine
  import crr_pkg::*;
#(
  parameter int MAX_SET = MAX_SET_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [CFG_W-1:0]   set_size_i,
  input  wire logic [CFG_W-1:0]   subset_size_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               op_i,
  input  wire logic [MASK_W-1:0]  member_mask_i,
  input  wire logic [IDX_W-1:0]   combo_index_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [INDEX_W-1:0] index_out_o,
  output logic      [MASK_W-1:0]  mask_out_o,
  output logic                    error_o
);

  localparam int NCapI = (MAX_SET < MASK_W) ? MAX_SET : MASK_W;
  localparam logic [CNT_W-1:0] NCap = CNT_W'(NCapI);

  crr_state_e         state_q, state_d;
  crr_op_e            op_q, op_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [CNT_W-1:0]   r_q, r_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   acc_q, acc_d;
  logic [MASK_W-1:0]  mask_q, mask_d;
  logic               range_err_q, range_err_d;
  logic               out_valid_q, out_valid_d;
  logic [INDEX_W-1:0] out_index_q, out_index_d;
  logic [MASK_W-1:0]  out_mask_q, out_mask_d;
  logic               out_err_q, out_err_d;

  logic [CNT_W-1:0]   n_eff;
  logic [MASK_W:0]    lim;
  logic [MASK_W-1:0]  valid_bits;
  logic               in_fire;
  logic               proc;
  logic               last;
  logic               out_free;
  logic [CNT_W-1:0]   a_full;
  logic [CNT_W-1:0]   r_n;
  logic [CNT_W-1:0]   cnt_n;
  logic [IDX_W-1:0]   acc_n;
  logic [MASK_W-1:0]  mask_n;
  logic               res_err;

  crr_step_req_t      step_req;
  crr_step_rsp_t      step_rsp;

  // Effective set size
  assign n_eff      = (set_size_i > NCap) ? NCap : set_size_i;
  assign lim        = (MASK_W+1)'(1) << n_eff;
  assign valid_bits = lim[MASK_W-1:0] - MASK_W'(1);

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;
  assign proc       = CNT_W'(pos_q) < n_eff;
  assign last       = (CNT_W'(pos_q) + CNT_W'(1)) >= n_eff;
  assign a_full     = n_eff - CNT_W'(1) - CNT_W'(pos_q);

  crr_step_unit u_step (
    .req_i (step_req),
    .rsp_o (step_rsp)
  );

  assign step_req = '{op: op_q, bit_in: mask_q[pos_q], a: a_full[POS_W-1:0],
                      r: r_q, acc: acc_q};

  // Working values after this position
  always_comb begin
    r_n    = r_q;
    cnt_n  = cnt_q;
    acc_n  = acc_q;
    mask_n = mask_q;
    if (proc) begin
      r_n   = step_rsp.r;
      acc_n = step_rsp.acc;
      if (op_q == OP_RANK) begin
        cnt_n = cnt_q + CNT_W'(step_rsp.take);
      end else if (step_rsp.take) begin
        mask_n = mask_q | (MASK_W'(1) << pos_q);
      end
    end
  end

  // Rank fails on range or popcount, unrank when the walk leaves a remainder
  assign res_err = (op_q == OP_RANK) ? (range_err_q | (cnt_n != subset_size_i))
                                     : ((r_n != '0) | (acc_n != '0));

  // Next state and datapath control
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    pos_d       = pos_q;
    r_d         = r_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    mask_d      = mask_q;
    range_err_d = range_err_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_index_d = out_index_q;
    out_mask_d  = out_mask_q;
    out_err_d   = out_err_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d     = ST_WALK;
          op_d        = crr_op_e'(op_i);
          pos_d       = '0;
          r_d         = subset_size_i;
          cnt_d       = '0;
          acc_d       = op_i ? combo_index_i : '0;
          mask_d      = op_i ? '0 : member_mask_i;
          range_err_d = ~op_i & ((member_mask_i & ~valid_bits) != '0);
        end
      end
      ST_WALK: begin
        if (!last) begin
          // Advance one position
          pos_d  = pos_q + POS_W'(1);
          r_d    = r_n;
          cnt_d  = cnt_n;
          acc_d  = acc_n;
          mask_d = mask_n;
        end else if (out_free) begin
          // Retire into the output register
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          out_err_d   = res_err;
          out_index_d = (res_err || op_q == OP_UNRANK) ? '0 : acc_n[INDEX_W-1:0];
          out_mask_d  = (res_err || op_q == OP_RANK) ? '0 : mask_n;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    pos_q       <= pos_d;
    r_q         <= r_d;
    cnt_q       <= cnt_d;
    acc_q       <= acc_d;
    mask_q      <= mask_d;
    range_err_q <= range_err_d;
    out_index_q <= out_index_d;
    out_mask_q  <= out_mask_d;
    out_err_q   <= out_err_d;
  end

  assign out_valid_o = out_valid_q;
  assign index_out_o = out_index_q;
  assign mask_out_o  = out_mask_q;
  assign error_o     = out_err_q;

endmodule
`default_nettype wire

### hw/rtl/combination_rank_unrank_top.sv
// Walk: one set position per cycle over the n positions, n being set_size capped
//   at MAX_SET and 16, then the result is registered in the output register.
// The single shared step unit walks the positions, so a new input transfer is
//   taken only once the previous walk has retired; a result waiting in the output
//   register lets one more input transfer in, then holds that walk at its last position.
// Reset: rst_ni asynchronous active low; registers return to n=16, k=8.
`timescale 1ns / 1ps
`default_nettype none
module combination_rank_unrank_top
  import crr_pkg::*;
#(
  parameter int MAX_SET = MAX_SET_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire logic [31:0]       s_axis_tdata_i,  // member_mask[15:0], combo_index[31:16]
  input  wire logic [0:0]        s_axis_tuser_i,  // op[0]
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic      [31:0]       m_axis_tdata_o,  // index_out[13:0], mask_out[29:14], zero
  output logic      [0:0]        m_axis_tuser_o,  // error[0]
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  logic [CFG_W-1:0]   set_size;
  logic [CFG_W-1:0]   subset_size;
  logic [INDEX_W-1:0] index_out;
  logic [MASK_W-1:0]  mask_out;
  logic               error;

  crr_apb_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .set_size_o    (set_size),
    .subset_size_o (subset_size)
  );

  crr_engine #(
    .MAX_SET (MAX_SET)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .set_size_i    (set_size),
    .subset_size_i (subset_size),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .op_i          (s_axis_tuser_i[0]),
    .member_mask_i (s_axis_tdata_i[MASK_W-1:0]),
    .combo_index_i (s_axis_tdata_i[MASK_W+IDX_W-1:MASK_W]),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .index_out_o   (index_out),
    .mask_out_o    (mask_out),
    .error_o       (error)
  );

  // Pack the result
  assign m_axis_tdata_o = {{(32-INDEX_W-MASK_W){1'b0}}, mask_out, index_out};
  assign m_axis_tuser_o = error;

endmodule
`default_nettype wire

### hw/rtl/crr_checker.sv
// Port-level checks of the combination rank/unrank block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
module crr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [31:0] m_axis_tdata_o,
  input wire logic [0:0]  m_axis_tuser_o,
  input wire logic        pready
);

  // Hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // Drop ready while an item is being walked
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while busy");

  // Zero the payload of a failed transfer
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o == 32'd0)
    else $error("error result carries data");

  // Keep a valid rank below C(16,8) and the pad bits clear
  a_rank_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[13:0] <= 14'd12869 && m_axis_tdata_o[31:30] == 2'b00)
    else $error("rank out of range");

  // Keep the register port always ready
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("register port not ready");

endmodule

bind combination_rank_unrank_top crr_checker u_crr_checker (.*);
`default_nettype wire
